// ----- rtl/sb64_pkg.sv -----
package sb64_pkg;

  // Register widths and indexes of the configuration port
  localparam int MaxLenWidth   = 21;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 21;

  localparam logic [CfgIndexWidth-1:0] CfgMaxTextLength  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRequireZeroEnd = 2'd1;

  localparam logic [MaxLenWidth-1:0] MaxTextLengthReset  = 21'd1398104;
  localparam logic                   RequireZeroEndReset = 1'b1;

  localparam int DefaultCountWidth = 21;

  // Depth of the job queue between front and back
  localparam int QueueDepth = 4;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusBadLength = 3'd1,
    StatusBadChar   = 3'd2,
    StatusBadPad    = 3'd3,
    StatusPadBits   = 3'd4,
    StatusNoZeroEnd = 3'd5
  } status_e;

  // One decoded group handed from front to back
  typedef struct packed {
    logic [23:0] value;       // three bytes, first byte in the top bits
    logic [1:0]  nbytes;      // data bytes to emit, 0 to 3
    logic        has_status;  // end of text: a status result follows
    status_e     code;
  } job_t;

  // Map a character onto its sextet; top bit set when it is in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h47)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c + 8'h04)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- rtl/sb64_front.sv -----
module sb64_front #(
  parameter int CountWidth = sb64_pkg::DefaultCountWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // character channel
  input  logic                                push,
  input  logic                                stall_i,
  input  logic [7:0]                          in_char_i,
  input  logic                                end_of_text_i,
  // configuration channel
  input  logic                                cfg_valid_i,
  input  logic [sb64_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [sb64_pkg::CfgDataWidth-1:0]   cfg_data_i,
  // job towards the queue
  output logic                                job_push_o,
  output sb64_pkg::job_t                      job_o
);
  import sb64_pkg::*;

  localparam int CmpWidth = (CountWidth > MaxLenWidth) ? CountWidth : MaxLenWidth;

  logic [MaxLenWidth-1:0] max_len_q;
  logic                   zero_end_q;

  logic [1:0]            pos_q, pos_d;
  logic [17:0]           bits_q, bits_d;
  logic                  pad_q, pad_d;
  status_e               err_q, err_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [7:0]            final_q, final_d;

  logic                  fire;
  logic                  is_pad;
  logic [6:0]            sx;
  logic [5:0]            sval;
  logic [CountWidth-1:0] count_inc;
  logic                  len_ok;
  status_e               char_err, grp_err, err_a, err_b;
  logic                  p2, p3;
  logic                  emit;
  logic [1:0]            nbytes;
  logic [23:0]           value;
  status_e               code;

  assign fire = push && !stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MaxTextLengthReset;
      zero_end_q <= RequireZeroEndReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaxTextLength) begin
        max_len_q <= cfg_data_i[MaxLenWidth-1:0];
      end else if (cfg_index_i == CfgRequireZeroEnd) begin
        zero_end_q <= cfg_data_i[0];
      end
    end
  end

  // Classify the character and advance the group
  always_comb begin
    is_pad    = (in_char_i == PadChar);
    sx        = sextet_of(in_char_i);
    sval      = (!is_pad && sx[6]) ? sx[5:0] : 6'd0;
    count_inc = (count_q != {CountWidth{1'b1}}) ? count_q + 1'b1 : count_q;
    len_ok    = CmpWidth'(count_inc) <= CmpWidth'(max_len_q);

    char_err = StatusOk;
    if (is_pad && pos_q < 2'd2) begin
      char_err = StatusBadPad;
    end else if (!is_pad && !sx[6]) begin
      char_err = StatusBadChar;
    end

    p2 = pad_q;
    p3 = is_pad;
    grp_err = StatusOk;
    if (p2 && !p3) begin
      grp_err = StatusBadPad;
    end else if ((p2 || p3) && !end_of_text_i) begin
      grp_err = StatusBadPad;
    end else if (p2 && bits_q[9:6] != 4'd0) begin
      grp_err = StatusPadBits;
    end else if (p3 && !p2 && bits_q[1:0] != 2'd0) begin
      grp_err = StatusPadBits;
    end

    err_a = (err_q != StatusOk) ? err_q : char_err;
    err_b = err_a;
    if (pos_q == 2'd3 && err_a == StatusOk) begin
      err_b = grp_err;
    end

    value  = {bits_q, sval};
    nbytes = 2'd3 - 2'(p2) - 2'(p3);
    emit   = (pos_q == 2'd3) && (err_b == StatusOk) && len_ok;

    final_d = final_q;
    if (emit) begin
      case (nbytes)
        2'd3:    final_d = value[7:0];
        2'd2:    final_d = value[15:8];
        default: final_d = value[23:16];
      endcase
    end

    if (count_inc[1:0] != 2'd0 || !len_ok) begin
      code = StatusBadLength;
    end else if (err_b != StatusOk) begin
      code = err_b;
    end else if (zero_end_q && final_d != 8'd0) begin
      code = StatusNoZeroEnd;
    end else begin
      code = StatusOk;
    end

    // next group state
    if (pos_q == 2'd3) begin
      pos_d  = 2'd0;
      bits_d = 18'd0;
      pad_d  = 1'b0;
    end else begin
      pos_d  = pos_q + 2'd1;
      bits_d = {bits_q[11:0], sval};
      pad_d  = pad_q || (is_pad && pos_q == 2'd2);
    end
    err_d   = err_b;
    count_d = count_inc;
    if (end_of_text_i) begin
      pos_d   = 2'd0;
      bits_d  = 18'd0;
      pad_d   = 1'b0;
      err_d   = StatusOk;
      count_d = '0;
      final_d = 8'd0;
    end
  end

  // Hand a job to the back whenever the item yields results
  assign job_push_o        = fire && (emit || end_of_text_i);
  assign job_o.value       = value;
  assign job_o.nbytes      = emit ? nbytes : 2'd0;
  assign job_o.has_status  = end_of_text_i;
  assign job_o.code        = code;

  // Hold group state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 2'd0;
      bits_q  <= 18'd0;
      pad_q   <= 1'b0;
      err_q   <= StatusOk;
      count_q <= '0;
      final_q <= 8'd0;
    end else if (fire) begin
      pos_q   <= pos_d;
      bits_q  <= bits_d;
      pad_q   <= pad_d;
      err_q   <= err_d;
      count_q <= count_d;
      final_q <= final_d;
    end
  end

endmodule

// ----- rtl/sb64_queue.sv -----
module sb64_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  sb64_pkg::job_t wr_data_i,
  input  logic           rd_i,
  output sb64_pkg::job_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import sb64_pkg::*;

  localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntWidth = $clog2(QueueDepth + 1);

  job_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntWidth'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sb64_back.sv -----
module sb64_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  // job from the queue
  input  logic           job_avail_i,
  input  sb64_pkg::job_t job_i,
  output logic           job_take_o,
  // result channel
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte_o,
  output logic           is_status_o,
  output logic [2:0]     status_code_o,
  output logic           run_last_o
);
  import sb64_pkg::*;

  job_t       job_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       in_status;
  logic       done;
  logic       fire;

  assign in_status = (idx_q >= job_q.nbytes);
  assign fire      = pop && valid_q;

  // Pick the current result of the held job
  always_comb begin
    out_byte_o    = 8'd0;
    is_status_o   = 1'b0;
    status_code_o = StatusOk;
    run_last_o    = 1'b0;
    if (in_status) begin
      is_status_o   = 1'b1;
      status_code_o = job_q.code;
      run_last_o    = 1'b1;
    end else begin
      case (idx_q)
        2'd0:    out_byte_o = job_q.value[23:16];
        2'd1:    out_byte_o = job_q.value[15:8];
        default: out_byte_o = job_q.value[7:0];
      endcase
      run_last_o = (idx_q == job_q.nbytes - 2'd1) && !job_q.has_status;
    end
  end

  assign done       = fire && run_last_o;
  assign job_take_o = job_avail_i && (!valid_q || done);
  assign empty      = !valid_q;

  // Load the next job or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (job_take_o) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (done) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
    end
  end

endmodule

// ----- rtl/strict_base64_decoder.sv -----
// Strict base64 decoder, standard alphabet with '=' padding.
// Character channel: drive in_char_i and end_of_text_i with push high; the
// character is taken at a rising edge where push is high and full is low.
// Result channel: while empty is low the oldest result is on the result
// ports; pop high at a rising edge takes it. Each completed four-character
// group gives up to three data bytes; the item flagged end_of_text_i adds a
// status result (is_status_o high) and clears all decoding state. run_last_o
// marks the last result caused by one character.
// Configuration: cfg_index_i 0 sets max_text_length, 1 sets require_zero_end;
// writes are always ready and should only be made while the block is idle.
// Timing: one character per cycle is taken while the four-entry job queue has
// room; a result passes the job queue and the back's job register, and results
// leave at one per cycle while pop is high, so a stalled receiver fills the
// job queue, after which full rises and holds the sender. Reset empties the
// queue, clears all group state and restores the register defaults.
module strict_base64_decoder #(
  parameter int CountWidth = sb64_pkg::DefaultCountWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         in_char_i,
  input  logic                               end_of_text_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         out_byte_o,
  output logic                               is_status_o,
  output logic [2:0]                         status_code_o,
  output logic                               run_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sb64_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [sb64_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import sb64_pkg::*;

  logic q_full, q_empty, q_take, job_push;
  job_t job_in, job_out;

  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  sb64_front #(
    .CountWidth(CountWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .stall_i      (q_full),
    .in_char_i    (in_char_i),
    .end_of_text_i(end_of_text_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  sb64_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_push),
    .wr_data_i(job_in),
    .rd_i     (q_take),
    .rd_data_o(job_out),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  sb64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_avail_i  (!q_empty),
    .job_i        (job_out),
    .job_take_o   (q_take),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .is_status_o  (is_status_o),
    .status_code_o(status_code_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ----- dv/tb_strict_base64_decoder.sv -----
`timescale 1ns / 1ps

module tb_strict_base64_decoder;
  import sb64_pkg::*;

  localparam int CountBits    = DefaultCountWidth;
  localparam int HoldOffLen   = 150;
  localparam int SettleCycles = 8;
  localparam int StuckLimit   = 2000;

  // One character offered to the block
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_item_t;

  // One decoded result as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    status_e    code;
    logic       last;
  } decoded_t;

  typedef logic [7:0] octet_q_t[$];

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     push          = 1'b0;
  logic                     full;
  logic [7:0]               in_char_i     = '0;
  logic                     end_of_text_i = 1'b0;
  logic                     empty;
  logic                     pop           = 1'b0;
  logic [7:0]               out_byte_o;
  logic                     is_status_o;
  logic [2:0]               status_code_o;
  logic                     run_last_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i   = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i    = '0;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Stimulus and expectations
  char_item_t pending_chars[$];
  decoded_t   decoded_results[$];
  char_item_t next_char;
  bit         no_idle           = 1'b0;
  int         hold_off_requests = 0;
  int         hold_off_served   = 0;
  int         hold_off_left     = 0;
  int         mismatches        = 0;
  int         chars_accepted    = 0;
  int         results_checked   = 0;
  int         status_checked    = 0;
  int         texts_built       = 0;
  int         stuck_cycles      = 0;

  // Decoder state as the block should hold it
  logic [1:0]           grp_pos    = '0;
  logic [17:0]          grp_bits   = '0;
  logic                 pad_seen   = 1'b0;
  status_e              first_err  = StatusOk;
  logic [CountBits-1:0] char_cnt   = '0;
  logic [7:0]           last_byte  = '0;
  logic [MaxLenWidth-1:0] max_len  = MaxTextLengthReset;
  logic                 zero_end   = RequireZeroEndReset;

  strict_base64_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .is_status_o   (is_status_o),
    .status_code_o (status_code_o),
    .run_last_o    (run_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Position of a character in the alphabet, -1 when it is not there
  function automatic int alphabet_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alphabet[i] == c) return i;
    end
    return -1;
  endfunction

  task automatic note_error(input status_e code);
    if (first_err == StatusOk) first_err = code;
  endtask

  // Advance the decoder state by one character and queue what it yields
  task automatic decode_char(input logic [7:0] c, input logic eot);
    logic        is_pad;
    logic        p2;
    logic        p3;
    logic [5:0]  sval;
    logic [23:0] word;
    logic [7:0]  octets[3];
    int          idx;
    int          nbytes;
    decoded_t    r;
    is_pad = (c == PadChar);
    sval   = '0;
    nbytes = 0;
    if (char_cnt != {CountBits{1'b1}}) char_cnt = char_cnt + 1'b1;

    if (is_pad) begin
      if (grp_pos < 2) note_error(StatusBadPad);
      else if (grp_pos == 2) pad_seen = 1'b1;
    end else begin
      idx = alphabet_index(c);
      if (idx < 0) note_error(StatusBadChar);
      else sval = 6'(idx);
    end

    if (grp_pos != 2'd3) begin
      grp_bits = {grp_bits[11:0], sval};
      grp_pos  = grp_pos + 1'b1;
    end else begin
      p2   = pad_seen;
      p3   = is_pad;
      word = {grp_bits, sval};
      if (p2 && !p3) note_error(StatusBadPad);
      else if ((p2 || p3) && !eot) note_error(StatusBadPad);
      else if (p2 && grp_bits[9:6] != 4'd0) note_error(StatusPadBits);
      else if (p3 && !p2 && grp_bits[1:0] != 2'd0) note_error(StatusPadBits);

      if (first_err == StatusOk && char_cnt <= max_len) begin
        nbytes    = 3 - int'(p2) - int'(p3);
        octets[0] = word[23:16];
        octets[1] = word[15:8];
        octets[2] = word[7:0];
        last_byte = octets[nbytes-1];
      end
      grp_pos  = '0;
      grp_bits = '0;
      pad_seen = 1'b0;
    end

    for (int i = 0; i < nbytes; i++) begin
      r.data      = octets[i];
      r.is_status = 1'b0;
      r.code      = StatusOk;
      r.last      = !eot && (i == nbytes - 1);
      decoded_results.push_back(r);
    end

    // Close the text with its status and clear everything
    if (eot) begin
      r.data      = '0;
      r.is_status = 1'b1;
      r.last      = 1'b1;
      if (char_cnt[1:0] != 2'd0 || char_cnt > max_len) r.code = StatusBadLength;
      else if (first_err != StatusOk) r.code = first_err;
      else if (zero_end && last_byte != 8'd0) r.code = StatusNoZeroEnd;
      else r.code = StatusOk;
      decoded_results.push_back(r);
      grp_pos   = '0;
      grp_bits  = '0;
      pad_seen  = 1'b0;
      first_err = StatusOk;
      char_cnt  = '0;
      last_byte = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Driver: offer pending characters, hold each one until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_char(in_char_i, end_of_text_i);
        chars_accepted++;
      end
      if (!push || !full) begin
        if (pending_chars.size() > 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
          next_char = pending_chars.pop_front();
          push          <= 1'b1;
          in_char_i     <= next_char.ch;
          end_of_text_i <= next_char.eot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    decoded_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (decoded_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_byte_o, 8'd0);
        end else begin
          want = decoded_results.pop_front();
          if (want.is_status) status_checked++;
          if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
          if (is_status_o !== want.is_status)
            report_mismatch("is_status", 8'(is_status_o), 8'(want.is_status));
          if (status_code_o !== want.code)
            report_mismatch("status_code", 8'(status_code_o), 8'(want.code));
          if (run_last_o !== want.last)
            report_mismatch("run_last", 8'(run_last_o), 8'(want.last));
        end
      end
      if (hold_off_served != hold_off_requests) begin
        hold_off_served = hold_off_requests;
        hold_off_left   = HoldOffLen;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t ns: no progress for %0d cycles", $time, StuckLimit);
      $display("FAIL strict_base64_decoder");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic add_char(input logic [7:0] c, input logic eot);
    char_item_t it;
    it.ch  = c;
    it.eot = eot;
    pending_chars.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
    texts_built++;
  endtask

  // Encode bytes as padded base64 text
  task automatic encode_bytes(input octet_q_t data, output octet_q_t text);
    logic [23:0] w;
    int          left;
    text = {};
    for (int i = 0; i < data.size(); i += 3) begin
      left = data.size() - i;
      w    = {data[i], (left > 1) ? data[i+1] : 8'd0, (left > 2) ? data[i+2] : 8'd0};
      text.push_back(alphabet[w[23:18]]);
      text.push_back(alphabet[w[17:12]]);
      text.push_back((left > 1) ? alphabet[w[11:6]] : PadChar);
      text.push_back((left > 2) ? alphabet[w[5:0]] : PadChar);
    end
  endtask

  // Queue one text: mostly well formed, the rest damaged or noise
  task automatic add_random_text(input int max_bytes);
    octet_q_t data;
    octet_q_t text;
    octet_q_t head;
    int       n;
    int       r;
    int       p;
    n = $urandom_range(1, max_bytes);
    for (int i = 0; i < n; i++) data.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0) data[n-1] = 8'd0;
    encode_bytes(data, text);
    if ($urandom_range(0, 99) >= 70) begin
      r = $urandom_range(0, text.size() - 1);
      case ($urandom_range(0, 6))
        0: text[r] = 8'($urandom_range(0, 255));
        1: if (text.size() > 1) text.delete(r);
        2: text.insert(r, alphabet[$urandom_range(0, 63)]);
        3: text[r] = PadChar;
        4: begin
          // disturb the sextet just before the first pad
          p = -1;
          foreach (text[i]) if (p < 0 && text[i] == PadChar) p = i;
          if (p > 0) text[p-1] = alphabet[$urandom_range(0, 63)];
          else text[r] = 8'($urandom_range(0, 255));
        end
        5: begin
          // a padded group that does not end the text
          data = {};
          data.push_back(8'($urandom_range(0, 255)));
          encode_bytes(data, head);
          text = {head, text};
        end
        default: begin
          text = {};
          for (int i = $urandom_range(1, 7); i > 0; i--) text.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    foreach (text[i]) add_char(text[i], i == text.size() - 1);
    texts_built++;
  endtask

  task automatic add_random_chars(input int count, input int max_bytes);
    int start;
    start = pending_chars.size();
    while (pending_chars.size() - start < count) add_random_text(max_bytes);
  endtask

  // Wait until every character is taken and every result has arrived
  task automatic drain();
    while (pending_chars.size() != 0 || push) @(posedge clk_i);
    while (decoded_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgMaxTextLength) max_len = MaxLenWidth'(val);
    else if (idx == CfgRequireZeroEnd) zero_end = val[0];
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed texts: character extremes, every error but bad length
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_text("AA");
    add_text("AAA=");
    add_text("A=AA");
    add_text("ab=c");
    add_text("QR==");
    add_text("zz+/");
    drain();

    // Reset settings, receiver held off while the sender keeps offering
    hold_off_requests++;
    add_random_chars(70, 9);
    drain();

    // Shortest legal length, no zero-end demand
    write_register(CfgMaxTextLength, CfgDataWidth'(4));
    write_register(CfgRequireZeroEnd, CfgDataWidth'(0));
    add_random_chars(35, 6);
    drain();

    // Longest length, zero end demanded, no idling on either side
    write_register(CfgMaxTextLength, CfgDataWidth'(2097151));
    write_register(CfgRequireZeroEnd, CfgDataWidth'(1));
    no_idle = 1'b1;
    add_random_chars(50, 9);
    drain();
    no_idle = 1'b0;

    // Mid-range length, sender pauses half way until all results are in
    write_register(CfgMaxTextLength, CfgDataWidth'(16));
    write_register(CfgRequireZeroEnd, CfgDataWidth'(0));
    add_random_chars(30, 9);
    drain();
    add_random_chars(30, 15);
    drain();

    $display("Decoded %0d texts, %0d characters, %0d results checked (%0d status).",
             texts_built, chars_accepted, results_checked, status_checked);
    $display("Four register settings used, length limit at both extremes.");
    if (mismatches == 0) begin
      $display("PASS strict_base64_decoder");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL strict_base64_decoder");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sb64_pkg.sv
rtl/sb64_front.sv
rtl/sb64_queue.sv
rtl/sb64_back.sv
rtl/strict_base64_decoder.sv
dv/tb_strict_base64_decoder.sv
